### hdl/sesu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesu_pkg
// Shared types, constants and the half-degree sine table for the segmenter.
// ----------------------------------------------------------------------------
package sesu_pkg;

    localparam int MAX_OBJECTS_DEF = 16;
    localparam int SINE_STEPS      = 181;
    localparam int DIV_STEPS       = 24;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic [15:0] THRESH_RST   = 16'd560;
    localparam logic [7:0]  MIN_WIDTH_RST = 8'd4;

    // operation codes carried on tuser
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    // configuration register indexes
    localparam logic REG_THRESH    = 1'b0;
    localparam logic REG_MIN_WIDTH = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;    // input request taken this cycle
        logic div_step;  // advance the divider by one quotient bit
        logic mul_load;  // register mean times sine
        logic out_load;  // move the finished object into the output register
    } t_cmd;

    typedef struct packed {
        logic emit_req;  // accepted item closes an object that is reported
        logic div_done;  // last quotient bit this cycle
        logic out_full;  // output register holds an untaken result
        logic out_taken; // downstream takes the result this cycle
    } t_status;

    typedef logic [SINE_STEPS-1:0][15:0] t_sine_tab;

    // sin(k/2 degrees) in Q1.15, seven-term Taylor series in Q30
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        longint unsigned x, x2, term;
        longint acc;
        for (int k = 0; k < SINE_STEPS; k++) begin
            x    = (longint'(k) * PI_Q30) / 360;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            term = ((term * x2) >> 30) / 6;   acc = acc - longint'(term);
            term = ((term * x2) >> 30) / 20;  acc = acc + longint'(term);
            term = ((term * x2) >> 30) / 42;  acc = acc - longint'(term);
            term = ((term * x2) >> 30) / 72;  acc = acc + longint'(term);
            term = ((term * x2) >> 30) / 110; acc = acc - longint'(term);
            term = ((term * x2) >> 30) / 156; acc = acc + longint'(term);
            if (acc < 0) begin
                acc = 0;
            end
            tab[k] = 16'((acc + 16384) >> 15);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

### hdl/sesu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesu_ctrl
// Sequencer: take a request, run the divider, the multiply and the output load.
// ----------------------------------------------------------------------------
module sesu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sesu_pkg::t_status i_status,
    output sesu_pkg::t_cmd    o_cmd
);

    sesu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sesu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sesu_pkg::S_IDLE: begin
                if (i_valid && i_status.emit_req) n_state = sesu_pkg::S_DIV;
            end
            sesu_pkg::S_DIV: begin
                if (i_status.div_done) n_state = sesu_pkg::S_MUL;
            end
            sesu_pkg::S_MUL: begin
                n_state = sesu_pkg::S_EMIT;
            end
            sesu_pkg::S_EMIT: begin
                if (!i_status.out_full || i_status.out_taken) n_state = sesu_pkg::S_IDLE;
            end
            default: n_state = sesu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            sesu_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            sesu_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            sesu_pkg::S_MUL:  o_cmd.mul_load = 1'b1;
            sesu_pkg::S_EMIT: o_cmd.out_load = !i_status.out_full || i_status.out_taken;
            default: o_ready = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_close_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.emit_req) |=> (r_state == sesu_pkg::S_DIV))
        else $error("object close did not start the divider");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == sesu_pkg::S_DIV))
        else $error("divider done outside divide state");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!i_status.out_full || i_status.out_taken))
        else $error("output register overwritten");
`endif

endmodule

### hdl/sesu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesu_dp
// Tracking state, edge detection, serial divider, chord multiply, output reg.
// ----------------------------------------------------------------------------
module sesu_dp #(
    parameter int MAX_OBJECTS = sesu_pkg::MAX_OBJECTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_angle,
    input  logic [15:0]       i_distance,
    input  sesu_pkg::t_cmd    i_cmd,
    output sesu_pkg::t_status o_status,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [71:0]       o_out_data
);

    localparam logic [4:0] MAX_CNT  = 5'(MAX_OBJECTS);
    localparam logic [4:0] DIV_LAST = 5'(sesu_pkg::DIV_STEPS - 1);

    logic [15:0] r_thresh;
    logic [7:0]  r_min_width;
    logic        r_tracking, r_primed;
    logic [7:0]  r_open_start, r_last_angle, r_tally;
    logic [15:0] r_last_dist;
    logic [23:0] r_sum;
    logic [4:0]  r_found;

    // snapshot of the closed object
    logic [4:0]  r_id;
    logic [7:0]  r_start, r_end, r_centre, r_width, r_divisor;
    logic [23:0] r_quot;
    logic [8:0]  r_rem;
    logic [4:0]  r_div_cnt;
    logic [15:0] r_sine;
    logic [31:0] r_prod;
    logic        r_out_valid;
    logic [71:0] r_out_data;

    logic [16:0] drop, rise;
    logic        is_drop, is_rise, closing;
    logic [8:0]  w_signed, sine_idx, angle_sum, rem_sh, rem_sub;
    logic        keep;

    always_comb begin
        drop      = {1'b0, r_last_dist} - {1'b0, i_distance};
        rise      = {1'b0, i_distance} - {1'b0, r_last_dist};
        is_drop   = !drop[16] && (drop[15:0] > r_thresh);
        is_rise   = !rise[16] && (rise[15:0] > r_thresh);
        closing   = r_tracking && ((i_op == sesu_pkg::OP_END) ||
                    ((i_op == sesu_pkg::OP_SAMPLE) && r_primed && is_rise));
        w_signed  = {1'b0, r_last_angle} - {1'b0, r_open_start};
        keep      = !w_signed[8] && (w_signed[7:0] >= r_min_width) && (r_found < MAX_CNT);
        sine_idx  = (w_signed <= 9'd180) ? w_signed : 9'd360 - w_signed;
        angle_sum = {1'b0, r_open_start} + {1'b0, r_last_angle};
        rem_sh    = {r_rem[7:0], r_quot[23]};
        rem_sub   = rem_sh - {1'b0, r_divisor};
    end

    assign o_status.emit_req  = closing && keep;
    assign o_status.div_done  = i_cmd.div_step && (r_div_cnt == DIV_LAST);
    assign o_status.out_full  = r_out_valid;
    assign o_status.out_taken = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= sesu_pkg::THRESH_RST;
            r_min_width <= sesu_pkg::MIN_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sesu_pkg::REG_THRESH:    r_thresh    <= i_cfg_wdata;
                sesu_pkg::REG_MIN_WIDTH: r_min_width <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.accept && i_op == sesu_pkg::OP_CLEAR)) begin
            r_tracking   <= 1'b0;
            r_primed     <= 1'b0;
            r_open_start <= '0;
            r_last_angle <= '0;
            r_last_dist  <= '0;
            r_sum        <= '0;
            r_tally      <= '0;
            r_found      <= '0;
        end else if (i_cmd.accept) begin
            if (closing) begin
                r_tracking <= 1'b0;
                if (keep) r_found <= r_found + 5'd1;
            end
            if (i_op == sesu_pkg::OP_SAMPLE) begin
                r_primed     <= 1'b1;
                r_last_angle <= i_angle;
                r_last_dist  <= i_distance;
                if (r_primed && !r_tracking && is_drop) begin
                    r_tracking   <= 1'b1;
                    r_open_start <= i_angle;
                    r_sum        <= {8'd0, i_distance};
                    r_tally      <= 8'd1;
                end else if (r_primed && r_tracking && !is_rise && r_tally != 8'hFF) begin
                    r_sum   <= r_sum + {8'd0, i_distance};
                    r_tally <= r_tally + 8'd1;
                end
            end
        end
    end

    // snapshot, then restoring division one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_status.emit_req) begin
            r_id      <= r_found + 5'd1;
            r_start   <= r_open_start;
            r_end     <= r_last_angle;
            r_centre  <= angle_sum[8:1];
            r_width   <= w_signed[7:0];
            r_sine    <= sesu_pkg::SINE_TAB[sine_idx[7:0]];
            r_divisor <= r_tally;
            r_quot    <= r_sum;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 5'd1;
            if (!rem_sub[8] || rem_sh >= {1'b0, r_divisor}) begin
                r_rem  <= rem_sh - {1'b0, r_divisor};
                r_quot <= {r_quot[22:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_quot <= {r_quot[22:0], 1'b0};
            end
        end
        if (i_cmd.mul_load) r_prod <= r_quot[15:0] * r_sine;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, r_prod[30:14], r_quot[15:0], r_width,
                           r_centre, r_end, r_start, r_id};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found <= MAX_CNT)
        else $error("object count past limit");
    a_tally_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tracking |-> (r_tally != 8'd0))
        else $error("open object with empty tally");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_data))
        else $error("output changed while waiting");
`endif

endmodule

### hdl/scan_edge_object_segmenter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_edge_object_segmenter_unit
// Segments objects from a sweep of range samples and reports each one.
// ----------------------------------------------------------------------------
// Sequence: an item closing a reported object is snapshotted on acceptance,
//   then runs 24 divider steps, the multiply and the output load.
// Throughput: one item per cycle when no object is reported; an item that
//   reports holds the input through the one-bit-a-cycle mean divider, the
//   multiply and output load, longer while an earlier result waits downstream.
// Reset: synchronous, active low; clears tracking, object count, output valid,
//   and loads edge_threshold = 560, min_width = 4.
module scan_edge_object_segmenter_unit #(
    parameter int MAX_OBJECTS = sesu_pkg::MAX_OBJECTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // request in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // angle[7:0], distance[23:8]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    // result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // object_id[4:0], start_deg[12:5], end_deg[20:13], centre_deg[28:21],
    // angular_width[36:29], mean_distance[52:37], chord_width[69:53], zero pad
    output logic [71:0] m_axis_tdata
);

    sesu_pkg::t_cmd    cmd;
    sesu_pkg::t_status status;

    // sequencer: accepts only when no object is being worked out
    sesu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: tracking state, divider, multiply and the output register
    sesu_dp #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_angle     (s_axis_tdata[7:0]),
        .i_distance  (s_axis_tdata[23:8]),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
